### hw/rtl/coh_pkg.sv
package coh_pkg;

  localparam int BINS_PER_AXIS = 200;
  localparam int COUNT_BITS    = 24;
  localparam int POS_BITS      = 12;
  localparam int BIN_STEP      = 10;

  localparam int BIN_BITS   = $clog2(BINS_PER_AXIS);
  localparam int BIN_DEPTH  = BINS_PER_AXIS * BINS_PER_AXIS;
  localparam int ADDR_BITS  = $clog2(BIN_DEPTH);
  localparam int ADDR_FIELD = 8;   // row_addr / col_addr / bin_row / bin_col

  // bin = floor((2*d + OFFSET_K) / DIVISOR), done as multiply by reciprocal
  localparam int OFFSET_K    = (BINS_PER_AXIS - 1) * BIN_STEP;
  localparam int DIVISOR     = 2 * BIN_STEP;
  localparam int NUM_MAX     = 2 * ((2 ** POS_BITS) - 1) + OFFSET_K;
  localparam int NUM_BITS    = $clog2(NUM_MAX + 1);
  localparam int NUM_SBITS   = NUM_BITS + 1;
  localparam int RECIP_SHIFT = NUM_BITS + $clog2(DIVISOR);
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int RECIP_BITS  = $clog2(RECIP + 1);
  localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_EVENT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_PEAK  = 2'd3
  } mode_t;

  localparam logic [1:0] PAIR_AB  = 2'd0;
  localparam logic [1:0] PAIR_AC  = 2'd1;
  localparam logic [1:0] PAIR_BC  = 2'd2;
  localparam logic [1:0] PAIR_ALL = 2'd3;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_BIN,
    S_ADDR,
    S_RD,
    S_UPD
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic bin_en;
    logic addr_en;
    logic rd_en;
    logic upd_en;
    logic clr_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

### hw/rtl/coh_ram.sv
module coh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/coh_ctrl.sv
module coh_ctrl import coh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  if (status.clr_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_BIN;
      S_BIN:  state_next = S_ADDR;
      S_ADDR: state_next = S_RD;
      S_RD:   state_next = S_UPD;
      S_UPD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLR:  cmd.clr_en = 1'b1;
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_BIN:  cmd.bin_en  = 1'b1;
      S_ADDR: cmd.addr_en = 1'b1;
      S_RD:   cmd.rd_en   = 1'b1;
      S_UPD:  cmd.upd_en  = out_free;
      default: cmd = '0;
    endcase
  end

  // result word loads as the old one leaves, so no result is dropped
  assign out_valid_next = cmd.upd_en ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_BIN)
    else $error("accepted word did not start binning");

  a_upd_free: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_en |-> (!out_valid || out_ready))
    else $error("update while result word still held");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_UPD)
    else $error("result raised outside update");

  a_no_clr_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_en |-> !cmd.rd_en && !cmd.upd_en && !in_ready)
    else $error("clearing pass overlaps item work");

endmodule

### hw/rtl/coh_datapath.sv
module coh_datapath import coh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_data,
  input  mode_t                 in_mode,
  input  logic [POS_BITS-1:0]   in_xa,
  input  logic [POS_BITS-1:0]   in_xb,
  input  logic [POS_BITS-1:0]   in_xc,
  input  logic [POS_BITS-1:0]   in_ya,
  input  logic [POS_BITS-1:0]   in_yb,
  input  logic [POS_BITS-1:0]   in_yc,
  input  logic                  in_ca,
  input  logic                  in_cb,
  input  logic                  in_cc,
  input  logic [ADDR_FIELD-1:0] in_row,
  input  logic [ADDR_FIELD-1:0] in_col,
  output logic                  out_accepted,
  output logic [ADDR_FIELD-1:0] out_row,
  output logic [ADDR_FIELD-1:0] out_col,
  output logic [COUNT_BITS-1:0] out_count,
  output logic [COUNT_BITS-1:0] out_peak
);

  logic [1:0]            pair_select;
  logic [ADDR_BITS-1:0]  clr_addr;
  logic [COUNT_BITS-1:0] peak;

  // latched item
  mode_t                 mode;
  logic [POS_BITS-1:0]   xa, xb, xc, ya, yb, yc;
  logic                  ca, cb, cc;
  logic [ADDR_FIELD-1:0] row_addr, col_addr;

  // bin stage
  logic [POS_BITS-1:0]   fx, sx, fy, sy;
  logic                  ok;
  logic [NUM_SBITS-1:0]  num_x, num_y;
  logic [PROD_BITS-1:0]  prod_x, prod_y;
  logic [NUM_BITS-1:0]   quot_x, quot_y;
  logic                  neg_x, neg_y, ev_ok;

  // address stage
  logic [BIN_BITS-1:0]   bin_x, bin_y, row_sel, col_sel;
  logic                  in_range;
  logic [ADDR_BITS-1:0]  idx;
  logic [ADDR_FIELD-1:0] row_echo, col_echo;
  logic                  hit;

  // update stage
  logic [COUNT_BITS-1:0] rd_count, inc_count, wr_count, cnt_next, peak_next;
  logic                  ram_we;
  logic                  acc_next;
  logic [ADDR_FIELD-1:0] row_next, col_next;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_select <= PAIR_AB;
      clr_addr    <= '0;
      peak        <= '0;
    end else begin
      if (cfg_we) pair_select <= cfg_data;
      if (cmd.clr_en) clr_addr <= clr_addr + ADDR_BITS'(1);
      if (cmd.upd_en) peak <= peak_next;
    end
  end

  assign status.clr_last = (clr_addr == ADDR_BITS'(BIN_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode     <= in_mode;
      xa       <= in_xa;
      xb       <= in_xb;
      xc       <= in_xc;
      ya       <= in_ya;
      yb       <= in_yb;
      yc       <= in_yc;
      ca       <= in_ca;
      cb       <= in_cb;
      cc       <= in_cc;
      row_addr <= in_row;
      col_addr <= in_col;
    end
  end

  always_comb begin
    case (pair_select)
      PAIR_AB: begin
        fx = xa; sx = xb; fy = ya; sy = yb; ok = ca && cb;
      end
      PAIR_AC: begin
        fx = xa; sx = xc; fy = ya; sy = yc; ok = ca && cc;
      end
      PAIR_BC: begin
        fx = xb; sx = xc; fy = yb; sy = yc; ok = cb && cc;
      end
      default: begin
        fx = xa; sx = xc; fy = ya; sy = yc; ok = ca && cb && cc;
      end
    endcase
  end

  assign num_x  = NUM_SBITS'(2 * int'(fx) - 2 * int'(sx) + OFFSET_K);
  assign num_y  = NUM_SBITS'(2 * int'(fy) - 2 * int'(sy) + OFFSET_K);
  assign prod_x = PROD_BITS'(num_x[NUM_BITS-1:0]) * PROD_BITS'(RECIP);
  assign prod_y = PROD_BITS'(num_y[NUM_BITS-1:0]) * PROD_BITS'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.bin_en) begin
      quot_x <= NUM_BITS'(prod_x >> RECIP_SHIFT);
      quot_y <= NUM_BITS'(prod_y >> RECIP_SHIFT);
      neg_x  <= num_x[NUM_SBITS-1];
      neg_y  <= num_y[NUM_SBITS-1];
      ev_ok  <= ok;
    end
  end

  // clamp to the histogram edge
  always_comb begin
    if (neg_x) begin
      bin_x = '0;
    end else if (int'(quot_x) > BINS_PER_AXIS - 1) begin
      bin_x = BIN_BITS'(BINS_PER_AXIS - 1);
    end else begin
      bin_x = BIN_BITS'(quot_x);
    end
    if (neg_y) begin
      bin_y = '0;
    end else if (int'(quot_y) > BINS_PER_AXIS - 1) begin
      bin_y = BIN_BITS'(BINS_PER_AXIS - 1);
    end else begin
      bin_y = BIN_BITS'(quot_y);
    end
  end

  assign in_range = (int'(row_addr) < BINS_PER_AXIS) && (int'(col_addr) < BINS_PER_AXIS);

  always_comb begin
    if (mode == MODE_EVENT) begin
      row_sel = bin_y;
      col_sel = bin_x;
    end else begin
      row_sel = BIN_BITS'(row_addr);
      col_sel = BIN_BITS'(col_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      idx <= ADDR_BITS'(row_sel) * ADDR_BITS'(BINS_PER_AXIS) + ADDR_BITS'(col_sel);
      if (mode == MODE_EVENT) begin
        row_echo <= ADDR_FIELD'(bin_y);
        col_echo <= ADDR_FIELD'(bin_x);
        hit      <= ev_ok;
      end else begin
        row_echo <= row_addr;
        col_echo <= col_addr;
        hit      <= in_range && (mode != MODE_PEAK);
      end
    end
  end

  assign inc_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_BITS'(1);

  always_comb begin
    ram_we    = 1'b0;
    wr_count  = '0;
    acc_next  = 1'b0;
    row_next  = '0;
    col_next  = '0;
    cnt_next  = '0;
    peak_next = peak;
    case (mode)
      MODE_EVENT: begin
        if (hit) begin
          ram_we   = 1'b1;
          wr_count = inc_count;
          acc_next = 1'b1;
          row_next = row_echo;
          col_next = col_echo;
          cnt_next = inc_count;
          if (inc_count > peak) peak_next = inc_count;
        end
      end
      MODE_READ: begin
        row_next = row_echo;
        col_next = col_echo;
        cnt_next = hit ? rd_count : '0;
      end
      MODE_CLEAR: begin
        ram_we   = hit;
        row_next = row_echo;
        col_next = col_echo;
      end
      MODE_PEAK: peak_next = '0;
      default: peak_next = peak;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      out_accepted <= acc_next;
      out_row      <= row_next;
      out_col      <= col_next;
      out_count    <= cnt_next;
      out_peak     <= peak_next;
    end
  end

  assign mem_we    = cmd.clr_en || (cmd.upd_en && ram_we);
  assign mem_waddr = cmd.clr_en ? clr_addr : idx;
  assign mem_wdata = cmd.clr_en ? '0 : wr_count;

  coh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rd_count)
  );

endmodule

### hw/rtl/coincidence_offset_histogram_top.sv
// channel | dir | handshake           | payload
// s       | in  | s_tvalid/s_tready   | s_tuser: mode; s_tdata: positions, flags, address
// m       | out | m_tvalid/m_tready   | m_tuser: accepted; m_tdata: bin, count, peak
// cfg     | in  | cfg_valid/cfg_ready | cfg_data: pair_select
//
// One word at a time: each accepted word passes through the bin, address, read and
// update steps before its result word is registered and the next word can be taken;
// the steps come from the read-modify-write of the count store plus the binning multiply.
// After reset the count store is swept to zero, one bin a cycle;
// s_tready stays low during the sweep, cfg writes are taken at any time.
// A stalled result word holds the item in its update step until taken.
module coincidence_offset_histogram_top import coh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [11:0] x_unit_a, [23:12] x_unit_b, [35:24] x_unit_c, [47:36] y_unit_a,
  // [59:48] y_unit_b, [71:60] y_unit_c, [72] clustered_a, [73] clustered_b,
  // [74] clustered_c, [82:75] row_addr, [90:83] col_addr, [95:91] zero
  input  logic [95:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] bin_row, [15:8] bin_col, [39:16] bin_count, [63:40] peak_count
  output logic [63:0] m_tdata,
  // [0] accepted
  output logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic                  out_accepted;
  logic [ADDR_FIELD-1:0] out_row, out_col;
  logic [COUNT_BITS-1:0] out_count, out_peak;

  assign cfg_ready = 1'b1;

  coh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  coh_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .in_mode      (mode_t'(s_tuser)),
    .in_xa        (s_tdata[11:0]),
    .in_xb        (s_tdata[23:12]),
    .in_xc        (s_tdata[35:24]),
    .in_ya        (s_tdata[47:36]),
    .in_yb        (s_tdata[59:48]),
    .in_yc        (s_tdata[71:60]),
    .in_ca        (s_tdata[72]),
    .in_cb        (s_tdata[73]),
    .in_cc        (s_tdata[74]),
    .in_row       (s_tdata[82:75]),
    .in_col       (s_tdata[90:83]),
    .out_accepted (out_accepted),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_count    (out_count),
    .out_peak     (out_peak)
  );

  assign m_tdata = {out_peak, out_count, out_col, out_row};
  assign m_tuser = out_accepted;

endmodule

### verif/coincidence_offset_histogram_top_test.sv
module coincidence_offset_histogram_top_test;
  import coh_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 7;
  localparam int PHASE_LEN  = 250;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] xa, xb, xc;
    logic [11:0] ya, yb, yc;
    logic        ca, cb, cc;
    logic [7:0]  row, col;
  } hit_word_t;

  typedef struct packed {
    logic        acc;
    logic [7:0]  row, col;
    logic [23:0] cnt, peak;
  } hist_result_t;

  typedef struct packed {
    logic [1:0]   pair;
    hit_word_t    word;
    logic         typed;
    hist_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  coincidence_offset_histogram_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow of the block state
  logic [COUNT_BITS-1:0] hist_counts [BIN_DEPTH];
  logic [COUNT_BITS-1:0] peak_now;
  logic [1:0]            pair_sel;
  logic [15:0]           touched_bins [$];   // {row, col} of recent hits

  hist_result_t pending_results [$];
  int           err_count = 0;
  int           cycle_count = 0;
  bit           calm = 1'b0;

  dir_row_t dir_table [N_DIRECTED] = '{
    '{PAIR_AB, '{MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      1, '{0, 0, 0, 0, 0}},
    '{PAIR_AB, '{MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 255},
      1, '{0, 255, 255, 0, 0}},
    '{PAIR_AB, '{MODE_EVENT, 0, 4095, 4095, 4095, 0, 4095, 1, 1, 1, 255, 255},
      1, '{1, 199, 0, 1, 1}},
    '{PAIR_AB, '{MODE_EVENT, 0, 4095, 4095, 4095, 0, 4095, 1, 1, 1, 255, 255},
      1, '{1, 199, 0, 2, 2}},
    '{PAIR_AB, '{MODE_EVENT, 10, 20, 30, 40, 50, 60, 1, 0, 1, 0, 0},
      1, '{0, 0, 0, 0, 2}},
    '{PAIR_AB, '{MODE_EVENT, 2048, 2048, 0, 2048, 2048, 0, 1, 1, 0, 0, 0},
      1, '{1, 99, 99, 1, 2}},
    // offsets right at the low and high bin edges
    '{PAIR_AB, '{MODE_EVENT, 1000, 1995, 7, 1000, 1985, 9, 1, 1, 0, 3, 4},
      0, '0},
    '{PAIR_AB, '{MODE_EVENT, 1994, 1000, 7, 1995, 1000, 9, 1, 1, 1, 3, 4},
      0, '0},
    '{PAIR_AB, '{MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 199, 0},
      1, '{0, 199, 0, 2, 2}},
    '{PAIR_AB, '{MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 199, 0},
      1, '{0, 199, 0, 0, 2}},
    '{PAIR_AB, '{MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 199, 0},
      1, '{0, 199, 0, 0, 2}},
    '{PAIR_AB, '{MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 200, 5},
      1, '{0, 200, 5, 0, 2}},
    '{PAIR_AB, '{MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 200},
      1, '{0, 0, 200, 0, 2}},
    '{PAIR_AB, '{MODE_PEAK, 4095, 4095, 4095, 4095, 4095, 4095, 1, 1, 1, 255, 255},
      1, '{0, 0, 0, 0, 0}},
    '{PAIR_AB, '{MODE_EVENT, 2048, 2048, 0, 2048, 2048, 0, 1, 1, 0, 0, 0},
      0, '0},
    '{PAIR_AC, '{MODE_EVENT, 100, 4095, 300, 700, 0, 650, 1, 0, 1, 0, 0},
      0, '0},
    '{PAIR_AC, '{MODE_EVENT, 100, 200, 300, 700, 0, 650, 1, 1, 0, 0, 0},
      0, '0},
    '{PAIR_BC, '{MODE_EVENT, 0, 3000, 2990, 0, 1200, 1230, 0, 1, 1, 0, 0},
      0, '0},
    '{PAIR_BC, '{MODE_EVENT, 0, 3000, 2990, 0, 1200, 1230, 1, 1, 0, 0, 0},
      0, '0},
    '{PAIR_ALL, '{MODE_EVENT, 2048, 0, 2048, 2048, 0, 2048, 1, 0, 1, 0, 0},
      0, '0},
    '{PAIR_ALL, '{MODE_EVENT, 2048, 0, 2048, 2048, 0, 2048, 1, 1, 1, 0, 0},
      0, '0},
    '{PAIR_ALL, '{MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 99, 99},
      0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] offset_to_bin(logic [11:0] first, logic [11:0] second);
    int d;
    int num;
    int b;
    d   = int'(first) - int'(second);
    num = 2 * d + (BINS_PER_AXIS - 1) * BIN_STEP;
    if (num < 0) begin
      return '0;
    end
    b = num / (2 * BIN_STEP);
    if (b > BINS_PER_AXIS - 1) begin
      b = BINS_PER_AXIS - 1;
    end
    return 8'(b);
  endfunction

  function automatic hist_result_t histogram_apply(hit_word_t w);
    hist_result_t res;
    logic         ok;
    logic [11:0]  fx, sx, fy, sy;
    int           idx;
    res = '0;
    case (w.mode)
      MODE_EVENT: begin
        case (pair_sel)
          PAIR_AB: begin
            ok = w.ca & w.cb; fx = w.xa; sx = w.xb; fy = w.ya; sy = w.yb;
          end
          PAIR_AC: begin
            ok = w.ca & w.cc; fx = w.xa; sx = w.xc; fy = w.ya; sy = w.yc;
          end
          PAIR_BC: begin
            ok = w.cb & w.cc; fx = w.xb; sx = w.xc; fy = w.yb; sy = w.yc;
          end
          default: begin
            ok = w.ca & w.cb & w.cc; fx = w.xa; sx = w.xc; fy = w.ya; sy = w.yc;
          end
        endcase
        if (ok) begin
          res.acc = 1'b1;
          res.col = offset_to_bin(fx, sx);
          res.row = offset_to_bin(fy, sy);
          idx = int'(res.row) * BINS_PER_AXIS + int'(res.col);
          if (hist_counts[idx] != COUNT_MAX) begin
            hist_counts[idx] = hist_counts[idx] + 1'b1;
          end
          res.cnt = hist_counts[idx];
          if (res.cnt > peak_now) begin
            peak_now = res.cnt;
          end
          touched_bins.push_back({res.row, res.col});
          if (touched_bins.size() > 32) begin
            void'(touched_bins.pop_front());
          end
        end
      end
      MODE_READ, MODE_CLEAR: begin
        res.row = w.row;
        res.col = w.col;
        if (w.row < BINS_PER_AXIS && w.col < BINS_PER_AXIS) begin
          idx = int'(w.row) * BINS_PER_AXIS + int'(w.col);
          if (w.mode == MODE_CLEAR) begin
            hist_counts[idx] = '0;
          end
          res.cnt = hist_counts[idx];
        end
      end
      default: begin
        peak_now = '0;
      end
    endcase
    res.peak = peak_now;
    return res;
  endfunction

  task automatic send_word(hit_word_t w);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.mode;
    s_tdata  <= {5'b0, w.col, w.row, w.cc, w.cb, w.ca,
                 w.yc, w.yb, w.ya, w.xc, w.xb, w.xa};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait for every expected word to come back
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_pair(logic [1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    pair_sel = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 10) begin
        $display("mismatch %s: expected %0d, got %0d", tag, want, got);
      end
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      m_tready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk) begin
    hist_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected result word: %h / %b", m_tdata, m_tuser);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.acc), 32'(m_tuser[0]));
        check_field("bin_row", 32'(want.row), 32'(m_tdata[7:0]));
        check_field("bin_col", 32'(want.col), 32'(m_tdata[15:8]));
        check_field("bin_count", 32'(want.cnt), 32'(m_tdata[39:16]));
        check_field("peak_count", 32'(want.peak), 32'(m_tdata[63:40]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    hit_word_t    w;
    hist_result_t pred;
    logic [15:0]  t;
    int           i;
    int           ph;
    int           k;
    int           n_rand;
    int           p;
    int           r;

    foreach (hist_counts[j]) hist_counts[j] = '0;
    peak_now = '0;
    pair_sel = PAIR_AB;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < N_DIRECTED; i++) begin
      if (dir_table[i].pair != pair_sel) begin
        settle();
        write_pair(dir_table[i].pair);
      end
      send_word(dir_table[i].word);
      pred = histogram_apply(dir_table[i].word);
      pending_results.push_back(dir_table[i].typed ? dir_table[i].want : pred);
    end

    // random phases, one pair setting each
    n_rand = 0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_pair(ph == 0 ? PAIR_AB : ph == 1 ? PAIR_ALL : 2'($urandom_range(0, 3)));
      for (k = 0; k < PHASE_LEN; k++) begin
        calm = (n_rand >= 700 && n_rand < 1000);
        w.xa  = 12'($urandom); w.xb = 12'($urandom); w.xc = 12'($urandom);
        w.ya  = 12'($urandom); w.yb = 12'($urandom); w.yc = 12'($urandom);
        w.ca  = 1'($urandom);  w.cb = 1'($urandom);  w.cc = 1'($urandom);
        w.row = 8'($urandom);  w.col = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 62) begin
          w.mode = MODE_EVENT;
          if ($urandom_range(0, 99) < 80) begin
            {w.ca, w.cb, w.cc} = 3'b111;
          end
          // most events land on a small patch of bins so counts build up
          if ($urandom_range(0, 99) < 70) begin
            p = $urandom_range(60, 4035);
            w.xa = 12'(p);
            w.xb = 12'(p + 20 - int'($urandom_range(0, 40)));
            w.xc = 12'(p + 20 - int'($urandom_range(0, 40)));
            p = $urandom_range(60, 4035);
            w.ya = 12'(p);
            w.yb = 12'(p + 20 - int'($urandom_range(0, 40)));
            w.yc = 12'(p + 20 - int'($urandom_range(0, 40)));
          end
        end else begin
          w.mode = (r < 78) ? MODE_READ : (r < 94) ? MODE_CLEAR : MODE_PEAK;
          if (touched_bins.size() != 0 && $urandom_range(0, 99) < 70) begin
            t = touched_bins[$urandom_range(0, touched_bins.size() - 1)];
            {w.row, w.col} = t;
          end
        end
        send_word(w);
        pending_results.push_back(histogram_apply(w));
        n_rand++;
      end
    end
    calm = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
